### hw/rtl/mbrc_pkg.sv
package mbrc_pkg;

    localparam int unsigned MBRC_MAX_FRAME_BYTES = 256;
    localparam int unsigned MBRC_CPOS_W = 9;
    localparam int unsigned MBRC_MASK_W = 5;

    localparam logic [MBRC_MASK_W-1:0] MBRC_MASK_RESET = 5'h1F;
    localparam logic [15:0] MBRC_CRC_INIT = 16'hFFFF;
    localparam logic [15:0] MBRC_CRC_POLY = 16'hA001;

    localparam logic [7:0] FC_READ_COILS = 8'h01;
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTIPLE = 8'h10;
    localparam logic [7:0] FC_EXC_01 = 8'h81;
    localparam logic [7:0] FC_EXC_02 = 8'h82;
    localparam logic [7:0] FC_EXC_03 = 8'h83;
    localparam logic [7:0] FC_EXC_04 = 8'h84;
    localparam logic [7:0] FC_EXC_05 = 8'h85;
    localparam logic [7:0] FC_EXC_06 = 8'h86;
    localparam logic [7:0] FC_EXC_0F = 8'h8F;
    localparam logic [7:0] FC_EXC_10 = 8'h90;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_EXC = 2'd3;

    localparam logic [2:0] VERDICT_READ_OK = 3'd0;
    localparam logic [2:0] VERDICT_WRITE_OK = 3'd1;
    localparam logic [2:0] VERDICT_EXCEPTION = 3'd2;
    localparam logic [2:0] VERDICT_CRC_BAD = 3'd3;
    localparam logic [2:0] VERDICT_IGNORED = 3'd4;
    localparam logic [2:0] VERDICT_TOO_SHORT = 3'd5;

    localparam logic RESULT_PAYLOAD = 1'b0;
    localparam logic RESULT_VERDICT = 1'b1;

    typedef logic [MBRC_MASK_W-1:0] mask_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } rx_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [2:0]  verdict;
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [7:0]  data_byte_count;
        logic [15:0] register_address;
        logic [15:0] register_value;
    } result_item_t;

    typedef struct packed {
        logic         has_result;
        result_item_t item;
    } parse_out_t;

    function automatic logic [1:0] classify(input logic [7:0] code, input mask_t m);
        logic is_exc;
        is_exc = (code == FC_EXC_01) || (code == FC_EXC_02) || (code == FC_EXC_03)
              || (code == FC_EXC_04) || (code == FC_EXC_05) || (code == FC_EXC_06)
              || (code == FC_EXC_0F) || (code == FC_EXC_10);
        if (code == FC_READ_COILS && m[0])
            return KIND_READ;
        if (code == FC_READ_HOLDING && m[1])
            return KIND_READ;
        if (code == FC_WRITE_SINGLE && m[2])
            return KIND_WRITE;
        if (code == FC_WRITE_MULTIPLE && m[3])
            return KIND_WRITE;
        if (is_exc && m[4])
            return KIND_EXC;
        return KIND_NONE;
    endfunction

endpackage

### hw/rtl/mbrc_stream_if.sv
interface mbrc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/modbus_rtu_response_checker_core.sv
// Modbus RTU response checker. Takes one received frame byte per request on
// "frame", with frame_end set on the last byte, and checks the running
// CRC-16 and header fields of read coils/holding registers, single/multiple
// write echoes and exception responses. Payload bytes of read responses come
// out on "result" as they arrive; the final byte of each frame yields one
// verdict. Each accepted request passes through the input register and then the
// result register before its result is valid, and one byte per cycle is
// sustained while the result side keeps taking data: the byte-wise CRC update
// and frame bookkeeping settle combinationally between the input register and
// the result register. Function enables on "cfg" take effect from the next byte processed.
module modbus_rtu_response_checker_core import mbrc_pkg::*; #(
    parameter int unsigned MAX_FRAME_BYTES = MBRC_MAX_FRAME_BYTES
) (
    input logic         clk,
    input logic         rst_n,
    mbrc_stream_if.sink   frame,
    mbrc_stream_if.source result,
    mbrc_stream_if.sink   cfg
);

    logic         in_valid_reg;
    rx_item_t     in_item_reg;
    logic         out_valid_reg;
    result_item_t out_item_reg;
    mask_t        mask_reg;
    logic         advance;
    parse_out_t   parse_res;

    assign advance       = in_valid_reg && (!out_valid_reg || result.ready);
    assign frame.ready   = !in_valid_reg || advance;
    assign cfg.ready     = 1'b1;
    assign result.valid  = out_valid_reg;
    assign result.payload = out_item_reg;

    mbrc_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .mask  (mask_reg),
        .res   (parse_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= MBRC_MASK_RESET;
        else if (cfg.valid)
            mask_reg <= mask_t'(cfg.payload);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (frame.ready)
            in_valid_reg <= frame.valid;
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
            in_item_reg <= frame.payload;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= parse_res.has_result;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= parse_res.item;
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !advance)
        else $error("pending result overwritten");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("stalled request lost");

endmodule

### hw/rtl/mbrc_crc16.sv
module mbrc_crc16 import mbrc_pkg::*; (
    input  logic [15:0] crc,
    input  logic [7:0]  data,
    output logic [15:0] crc_next
);

    always_comb
    begin
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ MBRC_CRC_POLY;
            else
                c = c >> 1;
        end
        crc_next = c;
    end

endmodule

### hw/rtl/mbrc_parser.sv
module mbrc_parser import mbrc_pkg::*; #(
    parameter int unsigned MAX_FRAME_BYTES = MBRC_MAX_FRAME_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  rx_item_t   item,
    input  mask_t      mask,
    output parse_out_t res
);

    localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned CMP_W = MBRC_CPOS_W;

    logic [15:0]      crc_reg, crc_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       addr_b_reg, addr_b_next;
    logic [7:0]       fc_reg, fc_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic [15:0]      addr_w_reg, addr_w_next;
    logic [15:0]      value_w_reg, value_w_next;
    logic [15:0]      rcrc_reg, rcrc_next;

    logic [15:0]      crc_upd;
    logic             taken;
    logic [1:0]       kind;
    logic             cpos_ok;
    logic [CMP_W-1:0] cpos;
    logic [CMP_W-1:0] p_ext;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] need_len;
    logic             before_crc;
    logic             payload;
    logic [2:0]       verdict;

    mbrc_crc16 u_crc (
        .crc      (crc_reg),
        .data     (item.rx_byte),
        .crc_next (crc_upd)
    );

    always_comb
    begin
        taken        = pos_reg < POS_W'(MAX_FRAME_BYTES);
        addr_b_next  = addr_b_reg;
        fc_next      = fc_reg;
        cnt_next     = cnt_reg;
        addr_w_next  = addr_w_reg;
        value_w_next = value_w_reg;
        crc_next     = crc_reg;
        rcrc_next    = rcrc_reg;
        pos_next     = pos_reg;
        payload      = 1'b0;
        p_ext        = CMP_W'(pos_reg);

        if (taken)
        begin
            priority if (pos_reg == POS_W'(0))
                addr_b_next = item.rx_byte;
            else if (pos_reg == POS_W'(1))
                fc_next = item.rx_byte;
            else if (pos_reg == POS_W'(2))
            begin
                cnt_next    = item.rx_byte;
                addr_w_next = {item.rx_byte, 8'h00};
            end
            else if (pos_reg == POS_W'(3))
                addr_w_next = {addr_w_reg[15:8], item.rx_byte};
            else if (pos_reg == POS_W'(4))
                value_w_next = {item.rx_byte, 8'h00};
            else if (pos_reg == POS_W'(5))
                value_w_next = {value_w_reg[15:8], item.rx_byte};
        end

        kind = (pos_reg != POS_W'(0)) ? classify(fc_next, mask) : KIND_NONE;

        // read frames only know their CRC position once the byte count is in
        unique case (kind)
            KIND_READ:
            begin
                cpos_ok = pos_reg >= POS_W'(2);
                cpos    = CMP_W'(3) + CMP_W'(cnt_next);
            end
            KIND_WRITE:
            begin
                cpos_ok = 1'b1;
                cpos    = CMP_W'(6);
            end
            KIND_EXC:
            begin
                cpos_ok = 1'b1;
                cpos    = CMP_W'(3);
            end
            default:
            begin
                cpos_ok = 1'b0;
                cpos    = '0;
            end
        endcase

        before_crc = !cpos_ok || (p_ext < cpos);

        if (taken)
        begin
            if (before_crc)
            begin
                crc_next = crc_upd;
                payload  = (kind == KIND_READ) && (pos_reg >= POS_W'(3));
            end
            else if (p_ext == cpos)
                rcrc_next = {8'h00, item.rx_byte};
            else if (p_ext == CMP_W'(cpos + CMP_W'(1)))
                rcrc_next = {item.rx_byte, rcrc_reg[7:0]};
            pos_next = POS_W'(pos_reg + POS_W'(1));
        end

        count_ext = CMP_W'(pos_next);
        unique case (kind)
            KIND_READ:  need_len = CMP_W'(5) + CMP_W'(cnt_next);
            KIND_WRITE: need_len = CMP_W'(8);
            KIND_EXC:   need_len = CMP_W'(5);
            default:    need_len = '0;
        endcase

        priority if (pos_next < POS_W'(2))
            verdict = VERDICT_TOO_SHORT;
        else if (kind == KIND_NONE)
            verdict = VERDICT_IGNORED;
        else if (count_ext < need_len)
            verdict = VERDICT_TOO_SHORT;
        else if (rcrc_next != crc_next)
            verdict = VERDICT_CRC_BAD;
        else if (kind == KIND_READ)
            verdict = VERDICT_READ_OK;
        else if (kind == KIND_WRITE)
            verdict = VERDICT_WRITE_OK;
        else
            verdict = VERDICT_EXCEPTION;

        res.has_result            = item.frame_end || payload;
        res.item.result_kind      = item.frame_end ? RESULT_VERDICT : RESULT_PAYLOAD;
        res.item.payload_byte     = item.frame_end ? 8'h00 : item.rx_byte;
        res.item.verdict          = item.frame_end ? verdict : VERDICT_READ_OK;
        res.item.slave_address    = addr_b_next;
        res.item.function_code    = fc_next;
        res.item.data_byte_count  = (kind == KIND_READ && pos_next >= POS_W'(3))
                                    ? cnt_next : 8'h00;
        res.item.register_address = (item.frame_end && verdict == VERDICT_WRITE_OK)
                                    ? addr_w_next : 16'h0000;
        res.item.register_value   = (item.frame_end && verdict == VERDICT_WRITE_OK)
                                    ? value_w_next : 16'h0000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= MBRC_CRC_INIT;
            pos_reg     <= '0;
            addr_b_reg  <= '0;
            fc_reg      <= '0;
            cnt_reg     <= '0;
            addr_w_reg  <= '0;
            value_w_reg <= '0;
            rcrc_reg    <= '0;
        end
        else if (fire)
        begin
            if (item.frame_end)
            begin
                crc_reg     <= MBRC_CRC_INIT;
                pos_reg     <= '0;
                addr_b_reg  <= '0;
                fc_reg      <= '0;
                cnt_reg     <= '0;
                addr_w_reg  <= '0;
                value_w_reg <= '0;
                rcrc_reg    <= '0;
            end
            else
            begin
                crc_reg     <= crc_next;
                pos_reg     <= pos_next;
                addr_b_reg  <= addr_b_next;
                fc_reg      <= fc_next;
                cnt_reg     <= cnt_next;
                addr_w_reg  <= addr_w_next;
                value_w_reg <= value_w_next;
                rcrc_reg    <= rcrc_next;
            end
        end
    end

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.frame_end) |=> (pos_reg == '0 && crc_reg == MBRC_CRC_INIT))
        else $error("frame state not restarted after final byte");

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_FRAME_BYTES))
        else $error("byte position beyond frame limit");

    a_payload_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        (res.has_result && res.item.result_kind == RESULT_PAYLOAD)
            |-> (kind == KIND_READ && !item.frame_end && taken))
        else $error("payload byte outside a read response");

endmodule

### dv/tb_modbus_rtu_response_checker_core.sv
`timescale 1ns / 100ps

module tb_modbus_rtu_response_checker_core;
    import mbrc_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BYTES = 285;
    localparam int PHASE_COUNT = 6;
    localparam logic [7:0] EXC_CODES [8] = '{FC_EXC_01, FC_EXC_02, FC_EXC_03, FC_EXC_04,
                                             FC_EXC_05, FC_EXC_06, FC_EXC_0F, FC_EXC_10};

    logic clk;
    logic rst_n;

    mbrc_stream_if #(.payload_t(rx_item_t)) frame_if ();
    mbrc_stream_if #(.payload_t(result_item_t)) result_if ();
    mbrc_stream_if #(.payload_t(mask_t)) cfg_if ();

    modbus_rtu_response_checker_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    rx_item_t     rx_backlog[$];
    result_item_t awaited_results[$];

    // response tracker state
    mask_t       live_mask;
    logic [15:0] crc_acc;
    int          byte_pos;
    logic [7:0]  hdr_slave;
    logic [7:0]  hdr_code;
    logic [7:0]  hdr_count;
    logic [15:0] word_addr;
    logic [15:0] word_value;
    logic [15:0] crc_rx;

    logic frame_fire;
    logic calm;
    logic hold_go;
    logic result_hold;

    int fail_count;
    int bytes_queued;
    int payloads_seen;
    int mask_writes;
    int verdict_tally[6];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        c ^= {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ MBRC_CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [1:0] code_kind(input logic [7:0] code, input mask_t m);
        logic [1:0] k;
        k = KIND_NONE;
        case (code)
            FC_READ_COILS:     if (m[0]) k = KIND_READ;
            FC_READ_HOLDING:   if (m[1]) k = KIND_READ;
            FC_WRITE_SINGLE:   if (m[2]) k = KIND_WRITE;
            FC_WRITE_MULTIPLE: if (m[3]) k = KIND_WRITE;
            FC_EXC_01, FC_EXC_02, FC_EXC_03, FC_EXC_04,
            FC_EXC_05, FC_EXC_06, FC_EXC_0F, FC_EXC_10:
                if (m[4]) k = KIND_EXC;
            default: ;
        endcase
        return k;
    endfunction

    function automatic int crc_slot(input logic [1:0] k);
        case (k)
            KIND_READ:  return 3 + int'(hdr_count);
            KIND_WRITE: return 6;
            KIND_EXC:   return 3;
            default:    return 4096;
        endcase
    endfunction

    task automatic clear_frame();
        crc_acc = MBRC_CRC_INIT;
        byte_pos = 0;
        hdr_slave = '0;
        hdr_code = '0;
        hdr_count = '0;
        word_addr = '0;
        word_value = '0;
        crc_rx = '0;
    endtask

    task automatic track_response_byte(input logic [7:0] b, input logic last);
        int           p;
        int           cp;
        logic [1:0]   k;
        logic         pl;
        result_item_t r;
        p = byte_pos;
        pl = 1'b0;
        if (p < MBRC_MAX_FRAME_BYTES)
        begin
            case (p)
                0: hdr_slave = b;
                1: hdr_code = b;
                2:
                begin
                    hdr_count = b;
                    word_addr = {b, 8'h00};
                end
                3: word_addr[7:0] = b;
                4: word_value = {b, 8'h00};
                5: word_value[7:0] = b;
                default: ;
            endcase
            k = (p >= 1) ? code_kind(hdr_code, live_mask) : KIND_NONE;
            cp = (p >= 2 || k != KIND_READ) ? crc_slot(k) : 4096;
            if (p < cp)
            begin
                crc_acc = crc16_byte(crc_acc, b);
                pl = (k == KIND_READ) && (p >= 3);
            end
            else if (p == cp)
            begin
                crc_rx = {8'h00, b};
            end
            else if (p == cp + 1)
            begin
                crc_rx[15:8] = b;
            end
            byte_pos = p + 1;
        end

        k = (byte_pos >= 2) ? code_kind(hdr_code, live_mask) : KIND_NONE;
        r = '0;
        r.slave_address = hdr_slave;
        r.function_code = hdr_code;
        r.data_byte_count = (k == KIND_READ && byte_pos >= 3) ? hdr_count : 8'h00;

        if (!last)
        begin
            if (pl)
            begin
                r.result_kind = RESULT_PAYLOAD;
                r.payload_byte = b;
                awaited_results.push_back(r);
            end
        end
        else
        begin
            r.result_kind = RESULT_VERDICT;
            if (byte_pos < 2)
                r.verdict = VERDICT_TOO_SHORT;
            else if (k == KIND_NONE)
                r.verdict = VERDICT_IGNORED;
            else if (byte_pos < crc_slot(k) + 2)
                r.verdict = VERDICT_TOO_SHORT;
            else if (crc_rx != crc_acc)
                r.verdict = VERDICT_CRC_BAD;
            else if (k == KIND_READ)
                r.verdict = VERDICT_READ_OK;
            else if (k == KIND_WRITE)
            begin
                r.verdict = VERDICT_WRITE_OK;
                r.register_address = word_addr;
                r.register_value = word_value;
            end
            else
                r.verdict = VERDICT_EXCEPTION;
            awaited_results.push_back(r);
            clear_frame();
        end
    endtask

    function automatic string show(input result_item_t r);
        return $sformatf("kind %0d byte %02h verdict %0d slave %02h code %02h count %02h reg %04h value %04h",
                         r.result_kind, r.payload_byte, r.verdict, r.slave_address,
                         r.function_code, r.data_byte_count, r.register_address,
                         r.register_value);
    endfunction

    task automatic check_result(input result_item_t got);
        result_item_t want;
        if (awaited_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: unexpected result: %s", $time, show(got));
        end
        else
        begin
            want = awaited_results.pop_front();
            if (want.result_kind == RESULT_PAYLOAD)
                payloads_seen++;
            else
                verdict_tally[want.verdict]++;
            if (got.result_kind !== want.result_kind
                || got.payload_byte !== want.payload_byte
                || got.verdict !== want.verdict
                || got.slave_address !== want.slave_address
                || got.function_code !== want.function_code
                || got.data_byte_count !== want.data_byte_count
                || got.register_address !== want.register_address
                || got.register_value !== want.register_value)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("%0t: result mismatch", $time);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        end
    endtask

    // results are checked before the new byte is tracked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            frame_fire <= frame_if.valid && frame_if.ready;
            if (result_if.valid && result_if.ready)
                check_result(result_if.payload);
            if (frame_if.valid && frame_if.ready)
                track_response_byte(frame_if.payload.rx_byte, frame_if.payload.frame_end);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            frame_if.valid <= 1'b0;
        end
        else if (!frame_if.valid || frame_fire)
        begin
            if (rx_backlog.size() != 0 && (calm || $urandom_range(99) >= 23))
            begin
                frame_if.valid <= 1'b1;
                frame_if.payload <= rx_backlog.pop_front();
            end
            else
            begin
                frame_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
            result_if.ready <= !result_hold && (calm || $urandom_range(99) >= 23);
    end

    initial
    begin
        result_hold = 1'b0;
        wait (hold_go);
        @(negedge clk);
        result_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        result_hold <= 1'b0;
    end

    function automatic byte_q_t with_crc(input byte_q_t fb, input bit bad);
        logic [15:0] c;
        c = MBRC_CRC_INIT;
        foreach (fb[i])
            c = crc16_byte(c, fb[i]);
        if (bad)
            c ^= 16'(1 << $urandom_range(15));
        fb.push_back(c[7:0]);
        fb.push_back(c[15:8]);
        return fb;
    endfunction

    task automatic queue_frame(input byte_q_t fb, input bit ends);
        rx_item_t it;
        foreach (fb[i])
        begin
            it.rx_byte = fb[i];
            it.frame_end = ends && (i == fb.size() - 1);
            rx_backlog.push_back(it);
        end
        bytes_queued += fb.size();
    endtask

    task automatic random_frame();
        byte_q_t fb;
        int      sel;
        int      cnt;
        int      cut;
        bit      long_read;
        sel = $urandom_range(99);
        long_read = (sel >= 98);
        fb.delete();
        if (sel < 14)
        begin
            repeat ($urandom_range(1, 12))
                fb.push_back($urandom_range(255));
        end
        else
        begin
            fb.push_back($urandom_range(255));
            case (long_read ? 0 : $urandom_range(4))
                0, 1:
                begin
                    fb.push_back($urandom_range(1) ? FC_READ_COILS : FC_READ_HOLDING);
                    if (long_read)
                        cnt = $urandom_range(252, 255);
                    else if ($urandom_range(9) == 0)
                        cnt = $urandom_range(9, 40);
                    else
                        cnt = $urandom_range(0, 8);
                    fb.push_back(cnt);
                    repeat (cnt)
                        fb.push_back($urandom_range(255));
                end
                2, 3:
                begin
                    fb.push_back($urandom_range(1) ? FC_WRITE_SINGLE : FC_WRITE_MULTIPLE);
                    repeat (4)
                        fb.push_back($urandom_range(255));
                end
                default:
                begin
                    fb.push_back(EXC_CODES[$urandom_range(7)]);
                    fb.push_back($urandom_range(255));
                end
            endcase
            fb = with_crc(fb, $urandom_range(9) == 0);
            if (long_read || $urandom_range(11) == 0)
            begin
                repeat ($urandom_range(1, long_read ? 40 : 3))
                    fb.push_back($urandom_range(255));
            end
            if ($urandom_range(11) == 0)
            begin
                cut = $urandom_range(1, fb.size() - 1);
                fb = fb[0:cut-1];
            end
        end
        queue_frame(fb, 1'b1);
    endtask

    task automatic write_mask(input mask_t m);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.payload <= m;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        live_mask = m;
        mask_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        @(posedge clk);
        while ((rx_backlog.size() != 0 || frame_if.valid || awaited_results.size() != 0)
               && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        byte_q_t fb;
        mask_t   m;
        int      target;
        rst_n = 1'b0;
        frame_if.valid = 1'b0;
        frame_if.payload = '0;
        cfg_if.valid = 1'b0;
        cfg_if.payload = '0;
        result_if.ready = 1'b0;
        frame_fire = 1'b0;
        calm = 1'b0;
        hold_go = 1'b0;
        fail_count = 0;
        bytes_queued = 0;
        payloads_seen = 0;
        mask_writes = 0;
        foreach (verdict_tally[i])
            verdict_tally[i] = 0;
        live_mask = MBRC_MASK_RESET;
        clear_frame();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_mask(5'h1F);

        // single byte frame
        fb = '{8'hFF};
        queue_frame(fb, 1'b1);
        fb = '{8'h00, FC_EXC_01, 8'h02};
        queue_frame(with_crc(fb, 1'b0), 1'b1);
        // exception with corrupted crc
        fb = '{8'h7E, FC_EXC_10, 8'h04};
        queue_frame(with_crc(fb, 1'b1), 1'b1);
        fb = '{8'h01, FC_READ_HOLDING, 8'h00};
        queue_frame(with_crc(fb, 1'b0), 1'b1);
        // write echo with extreme words and a trailing byte
        fb = '{8'hFF, FC_WRITE_MULTIPLE, 8'hFF, 8'hFF, 8'h00, 8'h00};
        fb = with_crc(fb, 1'b0);
        fb.push_back(8'hA5);
        queue_frame(fb, 1'b1);
        // unknown code
        fb = '{8'h01, 8'h00};
        queue_frame(fb, 1'b1);
        // frame ends on a payload byte
        fb = '{8'h11, FC_READ_COILS, 8'h02, 8'h5A};
        queue_frame(fb, 1'b1);
        wait_idle();

        // read enable dropped in the middle of a frame
        fb = '{8'h33, FC_READ_COILS, 8'h02, 8'hC3, 8'h3C};
        fb = with_crc(fb, 1'b0);
        queue_frame(fb[0:3], 1'b0);
        wait_idle();
        write_mask(5'h1E);
        queue_frame(fb[4:$], 1'b1);
        wait_idle();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                1, 4:    m = $urandom_range(31);
                2:       m = 5'h00;
                default: m = 5'h1F;
            endcase
            write_mask(m);
            calm = (phase == 3);
            if (phase == PHASE_COUNT - 1)
                hold_go = 1'b1;
            target = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target)
                random_frame();
            wait_idle();
            calm = 1'b0;
        end

        if (awaited_results.size() != 0)
        begin
            $display("%0d expected results never arrived", awaited_results.size());
            fail_count += awaited_results.size();
        end

        $display("Sent %0d frame bytes over %0d enable mask settings; %0d payload bytes checked.",
                 bytes_queued, mask_writes, payloads_seen);
        $display("Verdicts: read ok %0d, write ok %0d, exception %0d, crc bad %0d, ignored %0d, short %0d.",
                 verdict_tally[VERDICT_READ_OK], verdict_tally[VERDICT_WRITE_OK],
                 verdict_tally[VERDICT_EXCEPTION], verdict_tally[VERDICT_CRC_BAD],
                 verdict_tally[VERDICT_IGNORED], verdict_tally[VERDICT_TOO_SHORT]);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
